>>> src/aprq_pkg.sv
// ----------------------------------------------------------------------------
// aprq_pkg: shared types and codes of the aging priority run queue
// Request and response payloads, queue entry and the per-cell control word.
// ----------------------------------------------------------------------------
package aprq_pkg;

    localparam logic       ACT_INSERT = 1'b0;
    localparam logic       ACT_RUN    = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REQUEUED = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic signed [7:0] PRI_MIN = 8'sh80;

    typedef struct packed {
        logic               action;
        logic [7:0]         proc_id;
        logic [7:0]         run_steps;
        logic signed [7:0]  priority_req;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         sel_id;
        logic signed [7:0]  new_priority;
        logic [7:0]         time_left;
        logic [3:0]         queue_count;
    } t_rsp;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [7:0]  pri;
        logic [7:0]         rtime;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REQUEUE,
        OP_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [7:0]  key;
        t_entry             ent;
    } t_cell_ctl;

endpackage

>>> src/aprq_req_if.sv
// ----------------------------------------------------------------------------
// aprq_req_if: request channel
// Valid/ready handshake carrying one queue command per transaction.
// ----------------------------------------------------------------------------
interface aprq_req_if import aprq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/aprq_rsp_if.sv
// ----------------------------------------------------------------------------
// aprq_rsp_if: response channel
// Valid/ready handshake carrying one result per transaction.
// ----------------------------------------------------------------------------
interface aprq_rsp_if import aprq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/aging_priority_run_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_run_queue: priority run queue with aging on each run
// Response: the result of each accepted request is held in a register.
// Throughput: one request per cycle while the response is taken; every queue
// slot updates in parallel from its neighbors, so an insert or a run updates all slots at once.
// Reset: synchronous active-low reset empties the queue and the response
// register; slot contents are not cleared, only their valid bits.
// ----------------------------------------------------------------------------
module aging_priority_run_queue import aprq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aprq_req_if.sink    i_req,
    aprq_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry           w_ent   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_ge;

    t_cell_ctl        w_ctl;
    t_cell_op         w_op;
    t_rsp             w_rsp;
    logic             w_accept;
    logic signed [7:0] w_pri_dec;
    logic [7:0]       w_time_dec;

    logic [CW-1:0]    r_count, n_count;
    t_rsp             r_out;
    logic             r_out_valid;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // aged head entry
    assign w_pri_dec  = (w_ent[0].pri == PRI_MIN) ? PRI_MIN : w_ent[0].pri - 8'sd1;
    assign w_time_dec = (w_ent[0].rtime == 8'd0) ? 8'd0 : w_ent[0].rtime - 8'd1;

    always_comb begin
        w_op            = OP_HOLD;
        w_ctl.key       = i_req.data.priority_req;
        w_ctl.ent.id    = i_req.data.proc_id;
        w_ctl.ent.pri   = i_req.data.priority_req;
        w_ctl.ent.rtime = i_req.data.run_steps;
        n_count         = r_count;
        w_rsp           = '0;
        if (i_req.data.action == ACT_INSERT) begin
            w_rsp.sel_id = i_req.data.proc_id;
            if (w_valid[QUEUE_DEPTH-1] || i_req.data.run_steps == 8'd0) begin
                w_rsp.status = ST_REJECTED;
            end else begin
                w_op               = OP_INSERT;
                n_count            = r_count + CW'(1);
                w_rsp.status       = ST_INSERTED;
                w_rsp.new_priority = i_req.data.priority_req;
                w_rsp.time_left    = i_req.data.run_steps;
            end
        end else if (!w_valid[0]) begin
            w_rsp.status = ST_EMPTY;
        end else begin
            w_ctl.key          = w_pri_dec;
            w_ctl.ent.id       = w_ent[0].id;
            w_ctl.ent.pri      = w_pri_dec;
            w_ctl.ent.rtime    = w_time_dec;
            w_rsp.sel_id       = w_ent[0].id;
            w_rsp.new_priority = w_pri_dec;
            w_rsp.time_left    = w_time_dec;
            if (w_time_dec == 8'd0) begin
                w_op         = OP_POP;
                n_count      = r_count - CW'(1);
                w_rsp.status = ST_FINISHED;
            end else begin
                w_op         = OP_REQUEUE;
                w_rsp.status = ST_REQUEUED;
            end
        end
        w_rsp.queue_count = 4'(n_count);
        w_ctl.op          = w_accept ? w_op : OP_HOLD;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_l_ent, w_r_ent;
        logic   w_l_valid, w_l_ge, w_r_valid, w_r_ge;

        if (g == 0) begin : g_first
            assign w_l_ent   = w_ctl.ent;
            assign w_l_valid = 1'b1;
            assign w_l_ge    = 1'b1;
        end else begin : g_mid_l
            assign w_l_ent   = w_ent[g-1];
            assign w_l_valid = w_valid[g-1];
            assign w_l_ge    = w_ge[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_r_ent   = w_ctl.ent;
            assign w_r_valid = 1'b0;
            assign w_r_ge    = 1'b0;
        end else begin : g_mid_r
            assign w_r_ent   = w_ent[g+1];
            assign w_r_valid = w_valid[g+1];
            assign w_r_ge    = w_ge[g+1];
        end

        aprq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_head        (g == 0),
            .i_left_ent    (w_l_ent),
            .i_left_valid  (w_l_valid),
            .i_left_ge     (w_l_ge),
            .i_right_ent   (w_r_ent),
            .i_right_valid (w_r_valid),
            .i_right_ge    (w_r_ge),
            .o_ent         (w_ent[g]),
            .o_valid       (w_valid[g]),
            .o_ge          (w_ge[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out <= w_rsp;
        end
    end

endmodule

>>> src/aprq_cell.sv
// ----------------------------------------------------------------------------
// aprq_cell: one slot of the sorted queue
// Holds one entry, compares it with the broadcast key and picks its next
// value from itself, its neighbors or the broadcast entry.
// ----------------------------------------------------------------------------
module aprq_cell import aprq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_head,
    input  t_entry    i_left_ent,
    input  logic      i_left_valid,
    input  logic      i_left_ge,
    input  t_entry    i_right_ent,
    input  logic      i_right_valid,
    input  logic      i_right_ge,
    output t_entry    o_ent,
    output logic      o_valid,
    output logic      o_ge
);

    t_entry r_ent,   n_ent;
    logic   r_valid, n_valid;

    assign o_ent   = r_ent;
    assign o_valid = r_valid;
    assign o_ge    = r_valid && ($signed(r_ent.pri) >= $signed(i_ctl.key));

    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        unique case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                // entries ahead of the new one stay, the rest move back one
                if (!o_ge) begin
                    n_ent = i_left_ge ? i_ctl.ent : i_left_ent;
                end
                n_valid = r_valid | i_left_valid;
            end
            OP_REQUEUE: begin
                // head leaves, followers move up until the reinsert point
                if (i_right_ge) begin
                    n_ent = i_right_ent;
                end else if (i_head || o_ge) begin
                    n_ent = i_ctl.ent;
                end
            end
            OP_POP: begin
                n_ent   = i_right_ent;
                n_valid = i_right_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_ent <= n_ent;
    end

endmodule
